// ===== rtl/core/twgmp_pkg.sv =====
package twgmp_pkg;

  localparam int unsigned CellW   = 8;   // grid cell value
  localparam int unsigned TotalW  = 16;  // pair table entry and result
  localparam int unsigned RowCfgW = 8;   // row_count register
  localparam int unsigned ColCfgW = 5;   // col_count register
  localparam int unsigned ApbW    = 32;
  localparam int unsigned ApbAddrW = 3;

  // Register map, byte address bit 2 selects the register
  localparam logic RegRowCount = 1'b0;
  localparam logic RegColCount = 1'b1;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Operations of the shared accumulator
  typedef enum logic [1:0] {
    AluNop   = 2'd0,
    AluClear = 2'd1,
    AluAdd   = 2'd2,
    AluMax   = 2'd3
  } alu_op_e;

  // Sequencer to datapath controls
  typedef struct packed {
    alu_op_e alu_op;
    logic    opnd_tbl;   // operand from pair table, else from grid store
    logic    grid_re;
    logic    tbl_re;
    logic    tbl_we;
    logic    res_load;
    logic    idle;
  } ctl_t;

endpackage

// ===== rtl/core/twgmp_if.sv =====
interface twgmp_cell_if;
  logic                          valid;
  logic                          ready;
  logic [twgmp_pkg::CellW-1:0]   cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface twgmp_total_if;
  logic                          valid;
  logic                          ready;
  logic [twgmp_pkg::TotalW-1:0]  best_total;

  modport source (output valid, output best_total, input ready);
  modport sink   (input valid, input best_total, output ready);
endinterface

// ===== rtl/core/two_walker_grid_max_path_dp.sv =====
// Two-walker grid maximum path. Cells arrive one transaction per cycle in
// row-major order and go into the grid store; the transaction that brings
// the count to row_count * col_count (both clamped to 1..MAX) starts the
// solve and no cells are taken until it ends. The solve runs bottom-up over
// column pairs with one shared accumulator and one pair-table read port:
// each pair of the last row clears, reads and adds its two grid cells (a
// shared cell once) and writes the table; every other row first takes the
// maximum over nine neighbour reads of the row below. The result sits in an
// output register; the next grid may load while it waits, and a solve holds
// at its end until that register is free. Stores need no clearing pass:
// every table entry whose value is used during a solve was written.
module two_walker_grid_max_path_dp #(
  parameter int unsigned MAX_ROWS = 128,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  twgmp_cell_if.sink                        cell_i,
  twgmp_total_if.source                     total_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [twgmp_pkg::ApbAddrW-1:0]    paddr,
  input  logic [twgmp_pkg::ApbW-1:0]        pwdata,
  output logic [twgmp_pkg::ApbW-1:0]        prdata,
  output logic                              pready
);

  localparam int unsigned GridDepth = MAX_ROWS * MAX_COLS;
  localparam int unsigned GridAw = (GridDepth > 1) ? $clog2(GridDepth) : 1;
  localparam int unsigned ColIw  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned ColW   = $clog2(MAX_COLS + 1);
  localparam int unsigned CntW   = $clog2(GridDepth + 1);
  localparam int unsigned TblAw  = 1 + 2 * ColIw;
  localparam int unsigned TblDepth = 2 ** TblAw;  // two banks

  // ---- configuration registers ------------------------------------------
  logic [twgmp_pkg::RowCfgW-1:0] row_cfg_q;
  logic [twgmp_pkg::ColCfgW-1:0] col_cfg_q;
  logic                          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q <= twgmp_pkg::RowCfgW'(1);
      col_cfg_q <= twgmp_pkg::ColCfgW'(1);
    end else if (cfg_we) begin
      if (paddr[2] == twgmp_pkg::RegRowCount) begin
        row_cfg_q <= pwdata[twgmp_pkg::RowCfgW-1:0];
      end else begin
        col_cfg_q <= pwdata[twgmp_pkg::ColCfgW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == twgmp_pkg::RegRowCount)
                ? twgmp_pkg::ApbW'(row_cfg_q) : twgmp_pkg::ApbW'(col_cfg_q);

  // Clamp the dimensions in use into 1..MAX
  logic [RowW-1:0]   rows_use;
  logic [ColW-1:0]   cols_use;
  logic [CntW-1:0]   cells_total;
  logic [GridAw-1:0] last_row_base;

  always_comb begin
    if (row_cfg_q == '0) begin
      rows_use = RowW'(1);
    end else if (32'(row_cfg_q) > MAX_ROWS) begin
      rows_use = RowW'(MAX_ROWS);
    end else begin
      rows_use = RowW'(row_cfg_q);
    end
    if (col_cfg_q == '0) begin
      cols_use = ColW'(1);
    end else if (32'(col_cfg_q) > MAX_COLS) begin
      cols_use = ColW'(MAX_COLS);
    end else begin
      cols_use = ColW'(col_cfg_q);
    end
  end

  assign cells_total   = CntW'(rows_use) * CntW'(cols_use);
  assign last_row_base = GridAw'(cells_total - CntW'(cols_use));

  // ---- cell intake ------------------------------------------------------
  twgmp_pkg::ctl_t   ctl;
  logic [CntW-1:0]   cnt_q, cnt_inc;
  logic              cell_acc;
  logic              grid_done;

  assign cell_i.ready = ctl.idle;
  assign cell_acc     = cell_i.valid && cell_i.ready;
  assign cnt_inc      = cnt_q + CntW'(1);
  // completes on reaching or passing the current size
  assign grid_done    = cell_acc && (cnt_inc >= cells_total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cell_acc) begin
      cnt_q <= grid_done ? '0 : cnt_inc;
    end
  end

  // ---- grid store -------------------------------------------------------
  logic [twgmp_pkg::CellW-1:0] grid_mem [GridDepth];
  logic [twgmp_pkg::CellW-1:0] grid_rd_q;
  logic [GridAw-1:0]           grid_raddr;

  always_ff @(posedge clk_i) begin
    if (cell_acc && (32'(cnt_q) < GridDepth)) begin
      grid_mem[cnt_q[GridAw-1:0]] <= cell_i.cell_value;
    end
    if (ctl.grid_re) begin
      grid_rd_q <= grid_mem[grid_raddr];
    end
  end

  // ---- pair table, two banks: row below and row being built -------------
  logic [twgmp_pkg::TotalW-1:0] tbl_mem [TblDepth];
  logic [twgmp_pkg::TotalW-1:0] tbl_rd_q;
  logic [TblAw-1:0]             tbl_raddr, tbl_waddr;
  logic [twgmp_pkg::TotalW-1:0] acc;

  always_ff @(posedge clk_i) begin
    if (ctl.tbl_we) begin
      tbl_mem[tbl_waddr] <= acc;
    end
    if (ctl.tbl_re) begin
      tbl_rd_q <= tbl_mem[tbl_raddr];
    end
  end

  // ---- sequencer and shared accumulator ---------------------------------
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || total_o.ready;

  twgmp_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (grid_done),
    .rows_i       (rows_use),
    .cols_i       (cols_use),
    .base_i       (last_row_base),
    .out_free_i   (out_free),
    .ctl_o        (ctl),
    .grid_raddr_o (grid_raddr),
    .tbl_raddr_o  (tbl_raddr),
    .tbl_waddr_o  (tbl_waddr)
  );

  twgmp_alu u_alu (
    .clk_i  (clk_i),
    .op_i   (ctl.alu_op),
    .opnd_i (ctl.opnd_tbl ? tbl_rd_q : twgmp_pkg::TotalW'(grid_rd_q)),
    .acc_o  (acc)
  );

  // ---- result register --------------------------------------------------
  logic [twgmp_pkg::TotalW-1:0] best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid_q <= 1'b1;
    end else if (total_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.res_load) begin
      best_q <= tbl_rd_q;
    end
  end

  assign total_o.valid      = out_valid_q;
  assign total_o.best_total = best_q;

  // ---- checks -----------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) < GridDepth)
    else $error("cell count beyond grid store");

  a_grid_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.grid_re |-> (32'(grid_raddr) < GridDepth))
    else $error("grid read outside store");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl.res_load))
    else $error("result shown without a finished solve");

endmodule

// ===== rtl/core/twgmp_alu.sv =====
// Shared accumulator: clear, saturating add, running maximum.
module twgmp_alu (
  input  logic                           clk_i,
  input  twgmp_pkg::alu_op_e             op_i,
  input  logic [twgmp_pkg::TotalW-1:0]   opnd_i,
  output logic [twgmp_pkg::TotalW-1:0]   acc_o
);

  logic [twgmp_pkg::TotalW-1:0] acc_q, acc_d;
  logic [twgmp_pkg::TotalW:0]   sum;

  assign sum = {1'b0, acc_q} + {1'b0, opnd_i};

  always_comb begin
    acc_d = acc_q;
    case (op_i)
      twgmp_pkg::AluNop:   acc_d = acc_q;
      twgmp_pkg::AluClear: acc_d = '0;
      twgmp_pkg::AluAdd:   acc_d = sum[twgmp_pkg::TotalW] ? twgmp_pkg::TotalMax
                                                          : sum[twgmp_pkg::TotalW-1:0];
      twgmp_pkg::AluMax:   acc_d = (opnd_i > acc_q) ? opnd_i : acc_q;
      default:             acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/twgmp_ctrl.sv =====
// Solve sequencer: walks rows bottom-up, pairs (a, b), and the nine moves.
module twgmp_ctrl #(
  parameter  int unsigned MAX_ROWS  = 128,
  parameter  int unsigned MAX_COLS  = 16,
  localparam int unsigned GridDepth = MAX_ROWS * MAX_COLS,
  localparam int unsigned GridAw    = (GridDepth > 1) ? $clog2(GridDepth) : 1,
  localparam int unsigned ColIw     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned RowW      = $clog2(MAX_ROWS + 1),
  localparam int unsigned ColW      = $clog2(MAX_COLS + 1),
  localparam int unsigned TblAw     = 1 + 2 * ColIw
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [RowW-1:0]       rows_i,
  input  logic [ColW-1:0]       cols_i,
  input  logic [GridAw-1:0]     base_i,    // grid address of the last row
  input  logic                  out_free_i,
  output twgmp_pkg::ctl_t       ctl_o,
  output logic [GridAw-1:0]     grid_raddr_o,
  output logic [TblAw-1:0]      tbl_raddr_o,
  output logic [TblAw-1:0]      tbl_waddr_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StCellA = 8'b0000_0010,
    StCellB = 8'b0000_0100,
    StAddB  = 8'b0000_1000,
    StNbr   = 8'b0001_0000,
    StWrite = 8'b0010_0000,
    StFetch = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [ColIw-1:0]   a_q, a_d, b_q, b_d;
  logic [RowW-1:0]    rleft_q, rleft_d;
  logic [ColW-1:0]    cols_q, cols_d;
  logic [GridAw-1:0]  base_q, base_d;
  logic               nbank_q, nbank_d;
  logic               first_q, first_d;
  logic [1:0]         di_q, di_d, dj_q, dj_d;
  logic               ok_q, ok_d;
  logic               last_q, last_d;

  logic [ColW:0]      na_w, nb_w;
  logic               nbr_ok;
  logic [ColIw-1:0]   na, nb;
  logic               b_end, a_end;
  logic [ColIw-1:0]   col_last;

  // neighbour column = a + di - 1, kept one up to avoid negatives
  assign na_w   = (ColW+1)'(a_q) + (ColW+1)'(di_q);
  assign nb_w   = (ColW+1)'(b_q) + (ColW+1)'(dj_q);
  assign nbr_ok = (na_w != '0) && (na_w <= (ColW+1)'(cols_q)) &&
                  (nb_w != '0) && (nb_w <= (ColW+1)'(cols_q));
  assign na     = ColIw'(na_w - (ColW+1)'(1));
  assign nb     = ColIw'(nb_w - (ColW+1)'(1));

  assign col_last = ColIw'(cols_q - ColW'(1));
  assign b_end    = (b_q == col_last);
  assign a_end    = (a_q == col_last);

  assign grid_raddr_o = base_q + GridAw'((state_q == StCellB) ? b_q : a_q);
  assign tbl_raddr_o  = (state_q == StFetch) ? {nbank_q, ColIw'(0), col_last}
                                             : {nbank_q, na, nb};
  assign tbl_waddr_o  = {~nbank_q, a_q, b_q};

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    rleft_d = rleft_q;
    cols_d  = cols_q;
    base_d  = base_q;
    nbank_d = nbank_q;
    first_d = first_q;
    di_d    = di_q;
    dj_d    = dj_q;
    ok_d    = ok_q;
    last_d  = last_q;
    ctl_o   = '{alu_op: twgmp_pkg::AluNop, default: 1'b0};

    case (state_q)
      StIdle: begin
        ctl_o.idle = 1'b1;
        if (start_i) begin
          cols_d  = cols_i;
          base_d  = base_i;
          rleft_d = rows_i - RowW'(1);
          first_d = 1'b1;
          a_d     = '0;
          b_d     = '0;
          di_d    = '0;
          dj_d    = '0;
          last_d  = 1'b0;
          state_d = StCellA;
        end
      end
      StCellA: begin
        // best of the row below first, then the row's own cells on top
        ctl_o.alu_op = twgmp_pkg::AluClear;
        if (first_q) begin
          ctl_o.grid_re = 1'b1;
          state_d = StCellB;
        end else begin
          ctl_o.tbl_re = 1'b1;
          ok_d    = nbr_ok;
          last_d  = 1'b0;
          dj_d    = (dj_q == 2'd2) ? 2'd0 : dj_q + 2'd1;
          di_d    = (dj_q == 2'd2) ? di_q + 2'd1 : di_q;
          state_d = StNbr;
        end
      end
      StNbr: begin
        ctl_o.opnd_tbl = 1'b1;
        ctl_o.alu_op   = ok_q ? twgmp_pkg::AluMax : twgmp_pkg::AluNop;
        if (last_q) begin
          ctl_o.grid_re = 1'b1;
          state_d = StCellB;
        end else begin
          ctl_o.tbl_re = 1'b1;
          ok_d   = nbr_ok;
          last_d = (di_q == 2'd2) && (dj_q == 2'd2);
          dj_d   = (dj_q == 2'd2) ? 2'd0 : dj_q + 2'd1;
          di_d   = (dj_q == 2'd2) ? di_q + 2'd1 : di_q;
        end
      end
      StCellB: begin
        ctl_o.alu_op  = twgmp_pkg::AluAdd;
        ctl_o.grid_re = 1'b1;
        state_d = StAddB;
      end
      StAddB: begin
        // shared cell counts once
        ctl_o.alu_op = (a_q != b_q) ? twgmp_pkg::AluAdd : twgmp_pkg::AluNop;
        state_d = StWrite;
      end
      StWrite: begin
        ctl_o.tbl_we = 1'b1;
        di_d    = '0;
        dj_d    = '0;
        last_d  = 1'b0;
        state_d = StCellA;
        if (!b_end) begin
          b_d = b_q + ColIw'(1);
        end else if (!a_end) begin
          b_d = '0;
          a_d = a_q + ColIw'(1);
        end else begin
          // row finished: it becomes the row below
          nbank_d = ~nbank_q;
          a_d     = '0;
          b_d     = '0;
          if (rleft_q == '0) begin
            state_d = StFetch;
          end else begin
            rleft_d = rleft_q - RowW'(1);
            base_d  = base_q - GridAw'(cols_q);
            first_d = 1'b0;
          end
        end
      end
      StFetch: begin
        ctl_o.tbl_re = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        if (out_free_i) begin
          ctl_o.res_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      nbank_q <= 1'b0;
      first_q <= 1'b1;
      ok_q    <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      nbank_q <= nbank_d;
      first_q <= first_d;
      ok_q    <= ok_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    rleft_q <= rleft_d;
    cols_q  <= cols_d;
    base_q  <= base_d;
    di_q    <= di_d;
    dj_q    <= dj_d;
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == StIdle))
    else $error("solve started while busy");

endmodule
